>>> rtl/rcv_pkg.sv
// Shared types, codes and constants for the rolling code channel validator.
package rcv_pkg;

    localparam int CHANNELS_DEF = 16;
    localparam logic [31:0] WINDOW_RESET = 32'h0000_0400;

    localparam logic [1:0] REQ_NORMAL    = 2'd0;
    localparam logic [1:0] REQ_STORE     = 2'd1;
    localparam logic [1:0] REQ_RESET_ONE = 2'd2;
    localparam logic [1:0] REQ_RESET_ALL = 2'd3;

    localparam logic [2:0] ST_GRANTED        = 3'd0;
    localparam logic [2:0] ST_DISABLED       = 3'd1;
    localparam logic [2:0] ST_OUTSIDE        = 3'd2;
    localparam logic [2:0] ST_STORED         = 3'd3;
    localparam logic [2:0] ST_RESET_DONE     = 3'd4;
    localparam logic [2:0] ST_RESET_CANCELED = 3'd5;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] decrypted_code;
        logic [7:0]  channel_byte;
        logic        reset_confirmed;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic       unlock;
        logic [3:0] channel_index;
    } res_t;

    typedef enum logic [0:0] {
        CTRL_IDLE,
        CTRL_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic load;    // capture request, start table read
        logic commit;  // apply update, write result register
    } dp_cmd_t;

    typedef struct packed {
        logic out_blocked;  // result register full and not being taken
    } dp_stat_t;

endpackage

>>> rtl/rolling_code_channel_validator.sv
// Top level of the rolling code channel validator.
// Requests enter on s_valid/s_ready with s_req (command, decrypted code, channel
// byte, reset confirmation); each gives one result on m_valid/m_ready with m_res
// (status, unlock, channel index). The window size is written through
// cfg_valid/cfg_data; cfg_ready is high whenever reset is released, write only
// while idle. s_ready and cfg_ready stay low while reset is held.
// A transferred request is captured together with its registered table read; its
// result is written to the output register when the controller commits it.
// A new request is taken only after the previous one is committed, since the code
// table's registered read is followed by the update in the controller.
// A finished result waits in the output register while the next request is
// taken; if that result is still held when the next one finishes, the
// controller stays in its execute state and s_ready stays low until m_ready.
// Reset (aresetn low, synchronous) disables all channels, sets the window to
// 1024 and empties the output register. Stored codes are kept in a table that
// is not cleared; a code is only used on a channel enabled by a store request.
module rolling_code_channel_validator #(
    parameter int CHANNELS = rcv_pkg::CHANNELS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  rcv_pkg::req_t s_req,
    output logic          m_valid,
    input  logic          m_ready,
    output rcv_pkg::res_t m_res,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [31:0]   cfg_data
);

    rcv_pkg::dp_cmd_t  cmd;
    rcv_pkg::dp_stat_t stat;

    assign cfg_ready = aresetn;

    rcv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rcv_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_req     (s_req),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

endmodule

>>> rtl/rcv_ctrl.sv
// Controller state machine: sequences accept, execute and result hand-off.
module rcv_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rcv_pkg::dp_stat_t stat,
    output rcv_pkg::dp_cmd_t  cmd
);

    rcv_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rcv_pkg::CTRL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rcv_pkg::CTRL_IDLE: begin
                if (s_valid) state_next = rcv_pkg::CTRL_EXEC;
            end
            rcv_pkg::CTRL_EXEC: begin
                if (!stat.out_blocked) state_next = rcv_pkg::CTRL_IDLE;
            end
            default: state_next = rcv_pkg::CTRL_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            rcv_pkg::CTRL_IDLE: begin
                // no transfer is taken while reset is held
                s_ready  = aresetn;
                cmd.load = s_valid && aresetn;
            end
            rcv_pkg::CTRL_EXEC: begin
                cmd.commit = !stat.out_blocked;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/rcv_dp.sv
// Datapath: channel reduction, code table, enable bits, window check, result register.
module rcv_dp #(
    parameter int CHANNELS = rcv_pkg::CHANNELS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  rcv_pkg::req_t     s_req,
    input  logic              cfg_valid,
    input  logic [31:0]       cfg_data,
    input  rcv_pkg::dp_cmd_t  cmd,
    output rcv_pkg::dp_stat_t stat,
    output logic              m_valid,
    input  logic              m_ready,
    output rcv_pkg::res_t     m_res
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [15:0] CH16 = 16'(CHANNELS);

    logic [31:0]         window_reg;
    logic [31:0]         code_mem [CHANNELS];
    logic [CHANNELS-1:0] enabled_reg;
    logic [31:0]         rd_code_reg;
    rcv_pkg::req_t       req_reg;
    logic [7:0]          chan_reg;
    logic                out_valid_reg;
    rcv_pkg::res_t       out_res_reg;

    logic [15:0]         chan_red;
    logic [CH_W-1:0]     rd_addr;
    logic [CH_W-1:0]     wr_addr;
    logic [31:0]         code_inc;
    logic [31:0]         code_diff;
    logic                code_wr;
    logic                en_set;
    logic                en_clr_one;
    logic                en_clr_all;
    rcv_pkg::res_t       res_next;

    // restoring reduction: channel_byte mod CHANNELS, one shifted multiple per step
    always_comb begin
        chan_red = {8'd0, s_req.channel_byte};
        for (int k = 7; k >= 0; k--) begin
            if (chan_red >= (CH16 << k)) chan_red = chan_red - (CH16 << k);
        end
    end

    assign rd_addr = chan_red[CH_W-1:0];
    assign wr_addr = chan_reg[CH_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= rcv_pkg::WINDOW_RESET;
        end else if (cfg_valid) begin
            window_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg     <= s_req;
            chan_reg    <= chan_red[7:0];
            rd_code_reg <= code_mem[rd_addr];
        end
        if (code_wr) begin
            code_mem[wr_addr] <= code_inc;
        end
    end

    assign code_inc  = req_reg.decrypted_code + 32'd1;
    assign code_diff = req_reg.decrypted_code - rd_code_reg;

    always_comb begin
        res_next               = '0;
        res_next.channel_index = chan_reg[3:0];
        code_wr                = 1'b0;
        en_set                 = 1'b0;
        en_clr_one             = 1'b0;
        en_clr_all             = 1'b0;
        unique case (req_reg.req_type)
            rcv_pkg::REQ_NORMAL: begin
                if (!enabled_reg[wr_addr]) begin
                    res_next.status = rcv_pkg::ST_DISABLED;
                end else if (code_diff >= window_reg) begin
                    res_next.status = rcv_pkg::ST_OUTSIDE;
                end else begin
                    res_next.status = rcv_pkg::ST_GRANTED;
                    res_next.unlock = 1'b1;
                    code_wr         = cmd.commit;
                end
            end
            rcv_pkg::REQ_STORE: begin
                res_next.status = rcv_pkg::ST_STORED;
                code_wr         = cmd.commit;
                en_set          = cmd.commit;
            end
            rcv_pkg::REQ_RESET_ONE: begin
                res_next.status = req_reg.reset_confirmed ? rcv_pkg::ST_RESET_DONE
                                                          : rcv_pkg::ST_RESET_CANCELED;
                en_clr_one      = cmd.commit && req_reg.reset_confirmed;
            end
            rcv_pkg::REQ_RESET_ALL: begin
                res_next.status        = req_reg.reset_confirmed ? rcv_pkg::ST_RESET_DONE
                                                                 : rcv_pkg::ST_RESET_CANCELED;
                res_next.channel_index = 4'd0;
                en_clr_all             = cmd.commit && req_reg.reset_confirmed;
            end
            default: begin
                res_next.status = rcv_pkg::ST_RESET_CANCELED;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg <= '0;
        end else if (en_clr_all) begin
            enabled_reg <= '0;
        end else if (en_set) begin
            enabled_reg[wr_addr] <= 1'b1;
        end else if (en_clr_one) begin
            enabled_reg[wr_addr] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_res_reg <= res_next;
        end
    end

    assign stat.out_blocked = out_valid_reg && !m_ready;
    assign m_valid          = out_valid_reg;
    assign m_res            = out_res_reg;

endmodule

>>> rtl/rcv_checker.sv
// Port-level checks for the rolling code channel validator, bound to the top level.
module rcv_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input rcv_pkg::req_t s_req,
    input logic          m_valid,
    input logic          m_ready,
    input rcv_pkg::res_t m_res
);

    // a waiting request stays put until transferred
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_req))
        else $error("request changed while waiting");

    // a held result stays put until transferred
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_res))
        else $error("result changed while stalled");

    a_unlock_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_res.unlock == (m_res.status == rcv_pkg::ST_GRANTED)))
        else $error("unlock does not match granted status");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_res.status <= rcv_pkg::ST_RESET_CANCELED))
        else $error("status code out of range");

    // one request in flight: no transfer in the cycle after a transfer
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while previous still executing");

endmodule

bind rolling_code_channel_validator rcv_checker u_rcv_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_req   (s_req),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_res   (m_res)
);

>>> dv/rolling_code_channel_validator_tb.sv
// Self-checking testbench for the rolling code channel validator.
module rolling_code_channel_validator_tb;
    import rcv_pkg::*;

    localparam int NCH         = CHANNELS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 160;

    typedef struct {
        req_t rq;
        bit   pinned;
        res_t want;
    } vec_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    req_t        s_req     = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    res_t        m_res;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;

    // predictor state
    logic [31:0] window_sz = WINDOW_RESET;
    logic [31:0] next_code [NCH];
    bit          chan_on   [NCH];
    bit          ever_stored [NCH];

    res_t        due_results [$];
    int          errors    = 0;
    int          req_count = 0;
    int          res_count = 0;
    int          status_seen [6];
    int          cycles    = 0;
    bit          s_calm    = 1'b0;
    bit          m_calm    = 1'b0;
    int          m_hold    = 0;

    rolling_code_channel_validator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Applies one request to the channel table and returns the outcome.
    function automatic res_t rolling_check(req_t r);
        int unsigned ch;
        logic [31:0] ahead;
        res_t        o;
        ch = r.channel_byte % NCH;
        o.status = ST_GRANTED;
        o.unlock = 1'b0;
        o.channel_index = ch[3:0];
        case (r.req_type)
            REQ_NORMAL: begin
                ahead = r.decrypted_code - next_code[ch];
                if (!chan_on[ch]) begin
                    o.status = ST_DISABLED;
                end else if (ahead >= window_sz) begin
                    o.status = ST_OUTSIDE;
                end else begin
                    next_code[ch] = r.decrypted_code + 32'd1;
                    o.status = ST_GRANTED;
                    o.unlock = 1'b1;
                end
            end
            REQ_STORE: begin
                next_code[ch] = r.decrypted_code + 32'd1;
                chan_on[ch] = 1'b1;
                ever_stored[ch] = 1'b1;
                o.status = ST_STORED;
            end
            REQ_RESET_ONE: begin
                if (r.reset_confirmed) begin
                    chan_on[ch] = 1'b0;
                    o.status = ST_RESET_DONE;
                end else begin
                    o.status = ST_RESET_CANCELED;
                end
            end
            default: begin
                o.channel_index = 4'd0;
                if (r.reset_confirmed) begin
                    for (int i = 0; i < NCH; i++) chan_on[i] = 1'b0;
                    o.status = ST_RESET_DONE;
                end else begin
                    o.status = ST_RESET_CANCELED;
                end
            end
        endcase
        return o;
    endfunction

    function automatic vec_t row(logic [1:0] kind, logic [31:0] code, logic [7:0] cbyte,
                                 logic conf, bit pin, logic [2:0] st, logic ul,
                                 logic [3:0] idx);
        vec_t v;
        v.rq.req_type        = kind;
        v.rq.decrypted_code  = code;
        v.rq.channel_byte    = cbyte;
        v.rq.reset_confirmed = conf;
        v.pinned             = pin;
        v.want.status        = st;
        v.want.unlock        = ul;
        v.want.channel_index = idx;
        return v;
    endfunction

    // Presents one request after a random gap and logs its expected outcome on transfer.
    task automatic send(input req_t r, input bit pinned, input res_t want);
        int   gap;
        res_t pred;
        gap = s_calm ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= r;
        do @(posedge aclk); while (!s_ready);
        pred = rolling_check(r);
        due_results.push_back(pinned ? want : pred);
        req_count++;
    endtask

    // Window writes happen only with the block drained.
    task automatic set_window(input logic [31:0] w);
        s_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        window_sz = w;
    endtask

    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            if ($urandom_range(0, 63) == 0) m_calm = !m_calm;
            m_hold = m_calm ? 0 : $urandom_range(0, 8);
        end else if (m_hold != 0) begin
            m_hold--;
        end
        m_ready <= (m_hold == 0);
    end

    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            res_count++;
            if (m_res.status < 3'd6) status_seen[m_res.status]++;
            if (due_results.size() == 0) begin
                $error("result with nothing outstanding: status=%0d unlock=%0d channel=%0d",
                       m_res.status, m_res.unlock, m_res.channel_index);
                errors++;
            end else begin
                want = due_results.pop_front();
                if (m_res.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_res.status);
                    errors++;
                end
                if (m_res.unlock !== want.unlock) begin
                    $error("unlock: expected %0d, got %0d", want.unlock, m_res.unlock);
                    errors++;
                end
                if (m_res.channel_index !== want.channel_index) begin
                    $error("channel_index: expected %0d, got %0d",
                           want.channel_index, m_res.channel_index);
                    errors++;
                end
            end
        end
    end

    initial begin
        vec_t        dir_tab [$];
        logic [31:0] win_list [5];
        req_t        r;
        int unsigned ch;
        int unsigned pick;
        logic [31:0] off;

        for (int i = 0; i < NCH; i++) begin
            next_code[i]   = '0;
            chan_on[i]     = 1'b0;
            ever_stored[i] = 1'b0;
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, default window of 1024.
        dir_tab.push_back(row(REQ_RESET_ALL, 32'h0, 8'hFF, 1'b0,
                              1, ST_RESET_CANCELED, 1'b0, 4'h0));
        dir_tab.push_back(row(REQ_RESET_ALL, 32'hFFFF_FFFF, 8'h37, 1'b1,
                              1, ST_RESET_DONE, 1'b0, 4'h0));
        dir_tab.push_back(row(REQ_RESET_ONE, 32'h0, 8'hFF, 1'b0,
                              1, ST_RESET_CANCELED, 1'b0, 4'hF));
        dir_tab.push_back(row(REQ_RESET_ONE, 32'h0, 8'h00, 1'b1,
                              1, ST_RESET_DONE, 1'b0, 4'h0));
        // stored code wraps to zero
        dir_tab.push_back(row(REQ_STORE, 32'hFFFF_FFFF, 8'h00, 1'b0,
                              1, ST_STORED, 1'b0, 4'h0));
        dir_tab.push_back(row(REQ_NORMAL, 32'h0, 8'h10, 1'b0,
                              1, ST_GRANTED, 1'b1, 4'h0));
        // replay of the code just used
        dir_tab.push_back(row(REQ_NORMAL, 32'h0, 8'h20, 1'b1,
                              1, ST_OUTSIDE, 1'b0, 4'h0));
        // last code inside the window, then first code past it
        dir_tab.push_back(row(REQ_NORMAL, 32'h400, 8'h00, 1'b0,
                              1, ST_GRANTED, 1'b1, 4'h0));
        dir_tab.push_back(row(REQ_NORMAL, 32'h801, 8'h00, 1'b0,
                              1, ST_OUTSIDE, 1'b0, 4'h0));
        dir_tab.push_back(row(REQ_STORE, 32'h1234_5678, 8'hFF, 1'b1,
                              1, ST_STORED, 1'b0, 4'hF));
        dir_tab.push_back(row(REQ_NORMAL, 32'h1234_5679, 8'hEF, 1'b0,
                              1, ST_GRANTED, 1'b1, 4'hF));
        dir_tab.push_back(row(REQ_RESET_ONE, 32'h0, 8'h0F, 1'b1,
                              1, ST_RESET_DONE, 1'b0, 4'hF));
        // disabled channel: in window and out of window both report disabled
        dir_tab.push_back(row(REQ_NORMAL, 32'h1234_567A, 8'h0F, 1'b0,
                              1, ST_DISABLED, 1'b0, 4'hF));
        dir_tab.push_back(row(REQ_NORMAL, 32'h0, 8'h1F, 1'b0,
                              1, ST_DISABLED, 1'b0, 4'hF));
        dir_tab.push_back(row(REQ_STORE, 32'h7FFF_FFFF, 8'h05, 1'b0,
                              1, ST_STORED, 1'b0, 4'h5));
        dir_tab.push_back(row(REQ_NORMAL, 32'h8000_0000, 8'h85, 1'b1,
                              0, '0, 1'b0, 4'h0));
        dir_tab.push_back(row(REQ_RESET_ALL, 32'h0, 8'h05, 1'b0,
                              1, ST_RESET_CANCELED, 1'b0, 4'h0));
        dir_tab.push_back(row(REQ_NORMAL, 32'h8000_0001, 8'h05, 1'b0,
                              0, '0, 1'b0, 4'h0));
        dir_tab.push_back(row(REQ_RESET_ALL, 32'h0, 8'hAA, 1'b1,
                              1, ST_RESET_DONE, 1'b0, 4'h0));
        dir_tab.push_back(row(REQ_NORMAL, 32'h8000_0002, 8'h05, 1'b0,
                              1, ST_DISABLED, 1'b0, 4'h5));
        dir_tab.push_back(row(REQ_NORMAL, 32'h801, 8'h00, 1'b0,
                              1, ST_DISABLED, 1'b0, 4'h0));
        dir_tab.push_back(row(REQ_STORE, 32'hAAAA_AAAA, 8'hF0, 1'b0,
                              1, ST_STORED, 1'b0, 4'h0));
        dir_tab.push_back(row(REQ_NORMAL, 32'h5555_5555, 8'h00, 1'b0,
                              0, '0, 1'b0, 4'h0));
        dir_tab.push_back(row(REQ_NORMAL, 32'hAAAA_AAAB, 8'h00, 1'b0,
                              0, '0, 1'b0, 4'h0));

        foreach (dir_tab[i]) send(dir_tab[i].rq, dir_tab[i].pinned, dir_tab[i].want);

        win_list[0] = 32'd1;
        win_list[1] = 32'hFFFF_FFFF;
        win_list[2] = $urandom_range(2, 64);
        win_list[3] = $urandom_range(1, 32'hFFFF_FFFF);
        win_list[4] = WINDOW_RESET;

        for (int ph = 0; ph < 5; ph++) begin
            set_window(win_list[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0) s_calm = ($urandom_range(0, 3) == 0);
                pick = $urandom_range(0, 99);
                ch   = $urandom_range(0, NCH - 1);
                r.channel_byte    = 8'(($urandom_range(0, 15) << 4) | ch);
                r.reset_confirmed = ($urandom_range(0, 3) != 0);
                r.decrypted_code  = $urandom;
                if (pick < 55)      r.req_type = REQ_NORMAL;
                else if (pick < 75) r.req_type = REQ_STORE;
                else if (pick < 90) r.req_type = REQ_RESET_ONE;
                else                r.req_type = REQ_RESET_ALL;
                // never look up a code that was never written
                if (r.req_type == REQ_NORMAL && !ever_stored[ch]) r.req_type = REQ_STORE;
                if (r.req_type == REQ_STORE && $urandom_range(0, 7) == 0)
                    r.decrypted_code = 32'hFFFF_FFFF - $urandom_range(0, 2);
                // most unlock attempts land around the window edges
                if (r.req_type == REQ_NORMAL && pick >= 5) begin
                    case ($urandom_range(0, 6))
                        0:       off = 32'd0;
                        1:       off = window_sz - 32'd1;
                        2:       off = window_sz;
                        3, 4:    off = $urandom % window_sz;
                        5:       off = 32'd0 - $urandom_range(1, 4);
                        default: off = $urandom_range(0, 3);
                    endcase
                    r.decrypted_code = next_code[ch] + off;
                end
                send(r, 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("%0d requests over 6 window settings, %0d results checked", req_count,
                 res_count);
        $display("granted %0d, disabled %0d, outside %0d, stored %0d, reset %0d, canceled %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5]);
        if (errors == 0 && due_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/rcv_pkg.sv
rtl/rcv_ctrl.sv
rtl/rcv_dp.sv
rtl/rolling_code_channel_validator.sv
rtl/rcv_checker.sv
dv/rolling_code_channel_validator_tb.sv
